// File: rtl/socks5_server_handshake_defines.svh
// Assertion macros shared by the SOCKS5 handshake RTL.
// Used by s5hs_queue; no other dependencies.
`ifndef SOCKS5_SERVER_HANDSHAKE_DEFINES_SVH
`define SOCKS5_SERVER_HANDSHAKE_DEFINES_SVH
// implication checked on every edge outside reset
`define S5_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// implication whose consequent is checked in the next cycle
`define S5_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: rtl/s5hs_pkg.sv
// Package for the SOCKS5 server handshake: types, codes and constants.
// No dependencies; used by every module under rtl.
package s5hs_pkg;
  localparam int MaxCredBytesDef = 8;

  typedef enum logic [2:0] {
    PH_GREET, PH_AUTH, PH_AUTH_PASS, PH_REQUEST, PH_DONE, PH_FAILED
  } phase_t;

  localparam logic [1:0] KIND_REPLY = 2'd0;
  localparam logic [1:0] KIND_ADDR  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_FAIL  = 2'd3;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_GREET   = 3'd1;
  localparam logic [2:0] ERR_METHOD  = 3'd2;
  localparam logic [2:0] ERR_AUTH    = 3'd3;
  localparam logic [2:0] ERR_REQVER  = 3'd4;
  localparam logic [2:0] ERR_CMD     = 3'd5;
  localparam logic [2:0] ERR_ATYP    = 3'd6;

  localparam logic [2:0] REG_AUTH_MODE = 3'd0;
  localparam logic [2:0] REG_USER_NAME = 3'd1;
  localparam logic [2:0] REG_USER_LEN  = 3'd2;
  localparam logic [2:0] REG_PASS_WORD = 3'd3;
  localparam logic [2:0] REG_PASS_LEN  = 3'd4;

  // Burst command from the front end to the back end.
  // A burst is: n_pre reply bytes (from pre[]), optional 10-byte reply,
  // optional single tail result. At least one result when queued.
  typedef struct packed {
    logic [1:0]  n_pre;     // 0..3 leading reply bytes
    logic [23:0] pre;       // byte i in bits 8i+7..8i
    logic        ten;       // send 10-byte reply
    logic [7:0]  ten_rep;   // REP byte of the 10-byte reply
    logic        tail;      // one final result follows
    logic [1:0]  tail_kind;
    logic [7:0]  tail_byte;
    logic [1:0]  tail_ak;
    logic [15:0] tail_port;
    logic [2:0]  tail_err;
  } burst_t;
endpackage

// File: rtl/s5hs_front.sv
// Front end: parses client bytes and turns each item into a burst command.
// Depends on s5hs_pkg.
module s5hs_front import s5hs_pkg::*; #(
  parameter int MaxCredBytes = MaxCredBytesDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic        req_type,
  input  logic [7:0]  rx_byte,
  input  logic        connect_ok,
  input  logic        auth_mode,
  input  logic [63:0] user_name,
  input  logic [3:0]  user_length,
  input  logic [63:0] pass_word,
  input  logic [3:0]  pass_length,
  output logic        cmd_valid,
  output burst_t      cmd
);
  phase_t      phase, phase_next;
  logic [8:0]  field_position, field_position_next;
  logic [7:0]  saved_length, saved_length_next;
  logic        offers_no_auth, offers_no_auth_next;
  logic        offers_user_pass, offers_user_pass_next;
  logic        auth_version_ok, auth_version_ok_next;
  logic        user_matches, user_matches_next;
  logic        pass_matches, pass_matches_next;
  logic [1:0]  request_addr_type, request_addr_type_next;
  logic [7:0]  port_high, port_high_next;

  logic [8:0] addr_end;
  logic       user_ok, pass_ok, auth_ok, method_ok;

  function automatic logic cred_ok(input logic [63:0] r, input logic [8:0] idx,
                                   input logic [7:0] b);
    logic ok;
    ok = (idx < 9'(MaxCredBytes)) && (r[8*idx[2:0] +: 8] == b);
    return ok;
  endfunction

  assign user_ok = cred_ok(user_name, field_position - 9'd2, rx_byte);
  assign pass_ok = cred_ok(pass_word, field_position, rx_byte) && pass_matches;
  assign addr_end = (request_addr_type == 2'd1) ? 9'd5 + {1'b0, saved_length}
                  : (request_addr_type == 2'd0) ? 9'd8 : 9'd20;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_GREET;
      field_position <= '0;
      saved_length <= '0;
      offers_no_auth <= 1'b0;
      offers_user_pass <= 1'b0;
      auth_version_ok <= 1'b0;
      user_matches <= 1'b1;
      pass_matches <= 1'b1;
      request_addr_type <= '0;
      port_high <= '0;
    end else if (fire) begin
      phase <= phase_next;
      field_position <= field_position_next;
      saved_length <= saved_length_next;
      offers_no_auth <= offers_no_auth_next;
      offers_user_pass <= offers_user_pass_next;
      auth_version_ok <= auth_version_ok_next;
      user_matches <= user_matches_next;
      pass_matches <= pass_matches_next;
      request_addr_type <= request_addr_type_next;
      port_high <= port_high_next;
    end
  end

  always_comb begin
    logic om, ou;
    phase_next = phase;
    field_position_next = field_position;
    saved_length_next = saved_length;
    offers_no_auth_next = offers_no_auth;
    offers_user_pass_next = offers_user_pass;
    auth_version_ok_next = auth_version_ok;
    user_matches_next = user_matches;
    pass_matches_next = pass_matches;
    request_addr_type_next = request_addr_type;
    port_high_next = port_high;
    cmd = '0;
    om = 1'b0;
    ou = 1'b0;
    method_ok = 1'b0;
    auth_ok = 1'b0;
    if (req_type) begin
      cmd.ten = 1'b1;
      cmd.ten_rep = connect_ok ? 8'h00 : 8'h01;
    end else begin
      unique case (phase)
        PH_GREET: begin
          if (field_position == 9'd0) begin
            auth_version_ok_next = (rx_byte == 8'h05);
            offers_no_auth_next = 1'b0;
            offers_user_pass_next = 1'b0;
            field_position_next = 9'd1;
          end else begin
            if (field_position == 9'd1) begin
              if (!auth_version_ok) begin
                cmd.tail = 1'b1;
                cmd.tail_kind = KIND_FAIL;
                cmd.tail_err = ERR_GREET;
                phase_next = PH_FAILED;
              end else begin
                saved_length_next = rx_byte;
                field_position_next = 9'd2;
                om = (rx_byte == 8'h00);
              end
            end else begin
              if (rx_byte == 8'h00) offers_no_auth_next = 1'b1;
              else if (rx_byte == 8'h02) offers_user_pass_next = 1'b1;
              if (field_position - 9'd1 >= {1'b0, saved_length}) om = 1'b1;
              else field_position_next = field_position + 9'd1;
            end
            if (om) begin
              // method selection reply
              field_position_next = '0;
              auth_version_ok_next = 1'b0;
              user_matches_next = 1'b1;
              pass_matches_next = 1'b1;
              method_ok = auth_mode ? offers_user_pass_next : offers_no_auth_next;
              cmd.n_pre = 2'd2;
              cmd.pre[7:0] = 8'h05;
              if (!method_ok) begin
                cmd.pre[15:8] = 8'hff;
                cmd.tail = 1'b1;
                cmd.tail_kind = KIND_FAIL;
                cmd.tail_err = ERR_METHOD;
                phase_next = PH_FAILED;
              end else begin
                cmd.pre[15:8] = auth_mode ? 8'h02 : 8'h00;
                phase_next = auth_mode ? PH_AUTH : PH_REQUEST;
              end
            end
          end
        end
        PH_AUTH: begin
          if (field_position == 9'd0) begin
            auth_version_ok_next = (rx_byte == 8'h01);
            field_position_next = 9'd1;
          end else if (field_position == 9'd1) begin
            saved_length_next = rx_byte;
            user_matches_next = (rx_byte == {4'd0, user_length});
            field_position_next = 9'd2;
          end else if (field_position < 9'd2 + {1'b0, saved_length}) begin
            if (!user_ok) user_matches_next = 1'b0;
            field_position_next = field_position + 9'd1;
          end else begin
            saved_length_next = rx_byte;
            pass_matches_next = (rx_byte == {4'd0, pass_length});
            field_position_next = '0;
            phase_next = PH_AUTH_PASS;
            if (rx_byte == 8'h00) begin
              ou = 1'b1;
              auth_ok = auth_version_ok && user_matches && pass_matches_next;
            end
          end
        end
        PH_AUTH_PASS: begin
          pass_matches_next = pass_ok;
          if (field_position + 9'd1 >= {1'b0, saved_length}) begin
            ou = 1'b1;
            auth_ok = auth_version_ok && user_matches && pass_ok;
          end else field_position_next = field_position + 9'd1;
        end
        PH_REQUEST: begin
          if (field_position == 9'd0) begin
            auth_version_ok_next = (rx_byte == 8'h05);
            field_position_next = 9'd1;
          end else if (field_position == 9'd1) begin
            offers_user_pass_next = (rx_byte == 8'h01);
            field_position_next = 9'd2;
          end else if (field_position == 9'd2) begin
            field_position_next = 9'd3;
          end else if (field_position == 9'd3) begin
            cmd.tail_kind = KIND_FAIL;
            if (!auth_version_ok) begin
              cmd.tail = 1'b1;
              cmd.tail_err = ERR_REQVER;
              phase_next = PH_FAILED;
            end else if (!offers_user_pass) begin
              cmd.ten = 1'b1;
              cmd.ten_rep = 8'h07;
              cmd.tail = 1'b1;
              cmd.tail_err = ERR_CMD;
              phase_next = PH_FAILED;
            end else if (rx_byte == 8'h01 || rx_byte == 8'h03 || rx_byte == 8'h04) begin
              request_addr_type_next = (rx_byte == 8'h01) ? 2'd0
                                     : (rx_byte == 8'h03) ? 2'd1 : 2'd2;
              field_position_next = 9'd4;
              cmd.tail_kind = KIND_REPLY;
            end else begin
              cmd.ten = 1'b1;
              cmd.ten_rep = 8'h08;
              cmd.tail = 1'b1;
              cmd.tail_err = ERR_ATYP;
              phase_next = PH_FAILED;
            end
          end else if (request_addr_type == 2'd1 && field_position == 9'd4) begin
            saved_length_next = rx_byte;
            field_position_next = 9'd5;
          end else if (field_position < addr_end) begin
            cmd.tail = 1'b1;
            cmd.tail_kind = KIND_ADDR;
            cmd.tail_byte = rx_byte;
            cmd.tail_ak = request_addr_type;
            field_position_next = field_position + 9'd1;
          end else if (field_position == addr_end) begin
            port_high_next = rx_byte;
            field_position_next = field_position + 9'd1;
          end else begin
            cmd.tail = 1'b1;
            cmd.tail_kind = KIND_DONE;
            cmd.tail_ak = request_addr_type;
            cmd.tail_port = {port_high, rx_byte};
            phase_next = PH_DONE;
          end
        end
        default: ;
      endcase
      if (ou) begin
        // auth status reply
        cmd.n_pre = 2'd2;
        cmd.pre[15:0] = {auth_ok ? 8'h00 : 8'h01, 8'h01};
        field_position_next = '0;
        if (!auth_ok) begin
          cmd.tail = 1'b1;
          cmd.tail_kind = KIND_FAIL;
          cmd.tail_err = ERR_AUTH;
          phase_next = PH_FAILED;
        end else phase_next = PH_REQUEST;
      end
    end
    cmd_valid = fire && (cmd.ten || cmd.tail || (cmd.n_pre != 2'd0));
  end
endmodule

// File: rtl/s5hs_queue.sv
// Two-entry queue of burst commands between front and back end.
// Depends on s5hs_pkg and the assertion macros header.
`include "socks5_server_handshake_defines.svh"
module s5hs_queue import s5hs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  burst_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output burst_t head
);
  burst_t     mem [2];
  logic       wptr, rptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

  assign head = mem[rptr];
  assign full = count == 2'd2;
  assign not_empty = count != 2'd0;

  `S5_ASSERT_IMP(a_no_overflow, push, !full || pop, "queue overflow")
  `S5_ASSERT_IMP(a_no_underflow, pop, not_empty, "queue underflow")
  `S5_ASSERT_IMP(a_count_range, 1'b1, count != 2'd3, "queue count out of range")
endmodule

// File: rtl/s5hs_back.sv
// Back end: expands burst commands into result transfers, one per cycle while res_ready is high.
// Depends on s5hs_pkg.
module s5hs_back import s5hs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_avail,
  input  burst_t      cmd,
  output logic        cmd_pop,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [1:0]  addr_kind,
  output logic [15:0] dest_port,
  output logic [2:0]  error_code,
  output logic        last
);
  // step 0..2: leading bytes, 3..12: ten-byte reply, 13: tail
  logic [3:0] step, step_next;
  logic       step_last;
  logic [3:0] first_step;
  logic       started;

  always_comb begin
    first_step = (cmd.n_pre != 2'd0) ? 4'd0 : cmd.ten ? 4'd3 : 4'd13;
  end

  // a fresh head command starts at its first result; later ones follow step
  logic [3:0] cur;
  assign cur = started ? step : first_step;

  always_comb begin
    logic [3:0] t;
    out_kind = KIND_REPLY;
    out_byte = '0;
    addr_kind = '0;
    dest_port = '0;
    error_code = ERR_NONE;
    t = '0;
    if (cur < 4'd3) out_byte = cmd.pre[8*cur[1:0] +: 8];
    else if (cur < 4'd13) begin
      t = cur - 4'd3;
      out_byte = (t == 4'd0) ? 8'h05 : (t == 4'd1) ? cmd.ten_rep
               : (t == 4'd3) ? 8'h01 : 8'h00;
    end else begin
      out_kind = cmd.tail_kind;
      out_byte = cmd.tail_byte;
      addr_kind = cmd.tail_ak;
      dest_port = cmd.tail_port;
      error_code = cmd.tail_err;
    end
    step_next = cur + 4'd1;
    if (step_next == {2'b00, cmd.n_pre} && cur < 4'd3)
      step_next = cmd.ten ? 4'd3 : 4'd13;
    step_last = (cur == 4'd13) || (cur == 4'd12 && !cmd.tail) ||
                (cur < 4'd3 && step_next == 4'd13 && !cmd.tail);
  end

  assign res_valid = cmd_avail;
  assign last = step_last;
  assign cmd_pop = cmd_avail && res_ready && step_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      step <= 4'd0;
    end else if (cmd_avail && res_ready) begin
      started <= !step_last;
      step <= step_last ? 4'd0 : step_next;
    end
  end
endmodule

// File: rtl/socks5_server_handshake.sv
// SOCKS5 server handshake: input byte parser, command queue, result sequencer.
// Accepted bytes' burst commands are registered in the command queue.
// Intake takes one input byte per cycle while in_ready is high; a burst
// of up to eleven results holds intake once the two-entry queue fills.
// Reset (rst, synchronous) returns to the greeting phase, clears the configuration registers and empties the queue.
// Depends on s5hs_pkg, s5hs_front, s5hs_queue, s5hs_back.
module socks5_server_handshake import s5hs_pkg::*; #(
  parameter int MaxCredBytes = MaxCredBytesDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  rx_byte,
  input  logic        connect_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [1:0]  addr_kind,
  output logic [15:0] dest_port,
  output logic [2:0]  error_code,
  output logic        last
);
  logic        auth_mode;
  logic [63:0] user_name, pass_word;
  logic [3:0]  user_length, pass_length;
  logic        fire, cmd_valid, q_full, q_ne, q_pop;
  burst_t      cmd, head;
  logic [2:0]  reg_idx;

  // registers at 8-byte spacing (64-bit data)
  assign reg_idx = paddr[5:3];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      auth_mode <= 1'b0;
      user_name <= '0;
      user_length <= '0;
      pass_word <= '0;
      pass_length <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_AUTH_MODE: auth_mode <= pwdata[0];
        REG_USER_NAME: user_name <= pwdata;
        REG_USER_LEN:  user_length <= pwdata[3:0];
        REG_PASS_WORD: pass_word <= pwdata;
        REG_PASS_LEN:  pass_length <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_AUTH_MODE: prdata = {63'd0, auth_mode};
      REG_USER_NAME: prdata = user_name;
      REG_USER_LEN:  prdata = {60'd0, user_length};
      REG_PASS_WORD: prdata = pass_word;
      REG_PASS_LEN:  prdata = {60'd0, pass_length};
      default:       prdata = '0;
    endcase
  end

  // intake stalls whenever the queue holds two commands
  assign in_ready = !q_full;
  assign fire = in_valid && in_ready;

  s5hs_front #(.MaxCredBytes(MaxCredBytes)) u_front (
    .clk, .rst, .fire, .req_type, .rx_byte, .connect_ok,
    .auth_mode, .user_name, .user_length, .pass_word, .pass_length,
    .cmd_valid, .cmd
  );

  s5hs_queue u_queue (
    .clk, .rst, .push(cmd_valid), .push_data(cmd), .full(q_full),
    .pop(q_pop), .not_empty(q_ne), .head
  );

  s5hs_back u_back (
    .clk, .rst, .cmd_avail(q_ne), .cmd(head), .cmd_pop(q_pop),
    .res_valid(out_valid), .res_ready(out_ready),
    .out_kind, .out_byte, .addr_kind, .dest_port, .error_code, .last
  );
endmodule
